// ===== src/mfhp_pkg.sv =====
// Package with the shared types and helpers of the MAC frame header parser.
`timescale 1ns / 1ps
`default_nettype none

package mfhp_pkg;

    localparam int unsigned PosWidth = 4;

    localparam logic [2:0]  FrameKindMask = 3'h7;
    localparam logic [1:0]  ModeRawShort  = 2'h2;
    localparam logic [1:0]  ModeRawExt    = 2'h3;

    localparam logic [1:0]  ModeNone      = 2'd0;
    localparam logic [1:0]  ModeShort     = 2'd1;
    localparam logic [1:0]  ModeExt       = 2'd2;

    localparam logic [PosWidth-1:0] PosFcLow   = 4'd0;
    localparam logic [PosWidth-1:0] PosFcHigh  = 4'd1;
    localparam logic [PosWidth-1:0] PosSeq     = 4'd2;
    localparam logic [PosWidth-1:0] PosPanLow  = 4'd3;
    localparam logic [PosWidth-1:0] PosPanHigh = 4'd4;
    localparam logic [PosWidth-1:0] PosAddr    = 4'd5;
    localparam logic [PosWidth-1:0] ShortLen   = 4'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic                header_valid;
        logic [2:0]          frame_kind;
        logic [3:0]          control_flags;
        logic [1:0]          dest_mode;
        logic [1:0]          src_mode;
        logic [7:0]          sequence_number;
        logic [15:0]         pan_id;
        logic [15:0]         dest_short;
        logic [15:0]         src_short;
        logic [7:0]          unit_specifier;
        logic [PosWidth-1:0] bytes_parsed;
    } out_item_t;

    function automatic logic [1:0] map_mode(input logic [1:0] raw);
        logic [1:0] mode;
        unique case (raw)
            ModeRawShort: mode = ModeShort;
            ModeRawExt:   mode = ModeExt;
            default:      mode = ModeNone;
        endcase
        return mode;
    endfunction

endpackage

`default_nettype wire

// ===== src/mfhp_stream_if.sv =====
// Valid/ready stream interface that carries one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface mfhp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/mac_frame_header_parser_top.sv =====
// Top level of the MAC frame header parser.
//
//   Channel   Direction   Transaction carries
//   frame     in          data_byte, frame_start, frame_end
//   header    out         one parsed header result per frame
//
// Each byte's fields are captured into the field registers in the cycle of its
// transaction, and a result lands in the result register at the same edge. A new
// byte can be taken in every cycle while the skid stage is empty. A stalled result
// moves into a skid stage, and frame bytes stop only when both result slots are
// full. After reset the parser is idle until a byte with frame_start.
`timescale 1ns / 1ps
`default_nettype none

module mac_frame_header_parser_top
    import mfhp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mfhp_stream_if.sink   frame,
    mfhp_stream_if.source header
);

    logic      res_valid;
    out_item_t res_item;
    logic      up_ready;

    assign frame.ready = up_ready;

    mfhp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid),
        .in_item   (frame.payload),
        .in_ready  (up_ready),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    mfhp_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_item  (res_item),
        .up_ready  (up_ready),
        .header    (header)
    );

endmodule

`default_nettype wire

// ===== src/mfhp_parser.sv =====
// Header field capture: position tracking, field registers and result building.
`timescale 1ns / 1ps
`default_nettype none

module mfhp_parser
    import mfhp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire in_item_t  in_item,
    input  wire logic      in_ready,
    output logic           res_valid,
    output out_item_t      res_item
);

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic                done_reg, done_next;
    logic [15:0]         cw_reg, cw_next;
    logic [7:0]          seq_reg, seq_next;
    logic [15:0]         pan_reg, pan_next;
    logic [15:0]         dest_reg, dest_next;
    logic [15:0]         src_reg, src_next;

    logic [PosWidth-1:0] pos_eff;
    logic                done_eff;
    logic [15:0]         cw_eff;
    logic [PosWidth-1:0] dest_end;
    logic [PosWidth-1:0] src_end;
    logic                accept;
    logic                emit_valid;
    logic                emit;
    logic [7:0]          spec;
    logic [7:0]          b;

    assign accept = in_valid && in_ready;
    assign b      = in_item.data_byte;

    always_comb
    begin
        pos_eff   = in_item.frame_start ? '0 : pos_reg;
        done_eff  = in_item.frame_start ? 1'b0 : done_reg;
        cw_eff    = in_item.frame_start ? '0 : cw_reg;
        pos_next  = pos_eff;
        done_next = done_eff;
        cw_next   = cw_eff;
        seq_next  = in_item.frame_start ? '0 : seq_reg;
        pan_next  = in_item.frame_start ? '0 : pan_reg;
        dest_next = in_item.frame_start ? '0 : dest_reg;
        src_next  = in_item.frame_start ? '0 : src_reg;
        emit       = 1'b0;
        emit_valid = 1'b0;
        spec       = '0;

        dest_end = PosAddr + ((cw_eff[11:10] == ModeRawShort) ? ShortLen : '0);
        src_end  = dest_end + ((cw_eff[15:14] == ModeRawShort) ? ShortLen : '0);

        if (!done_eff)
        begin
            pos_next = pos_eff + PosWidth'(1);
            if (pos_eff == PosFcLow)
            begin
                cw_next[7:0] = b;
            end
            else if (pos_eff == PosFcHigh)
            begin
                cw_next[15:8] = b;
            end
            else if (pos_eff == PosSeq)
            begin
                seq_next = b;
            end
            else if (pos_eff == PosPanLow)
            begin
                pan_next[7:0] = b;
            end
            else if (pos_eff == PosPanHigh)
            begin
                pan_next[15:8] = b;
            end
            else if (pos_eff < dest_end)
            begin
                if (pos_eff == PosAddr)
                begin
                    dest_next[7:0] = b;
                end
                else
                begin
                    dest_next[15:8] = b;
                end
            end
            else if (pos_eff < src_end)
            begin
                if (pos_eff == dest_end)
                begin
                    src_next[7:0] = b;
                end
                else
                begin
                    src_next[15:8] = b;
                end
            end
            else
            begin
                done_next  = 1'b1;
                emit       = 1'b1;
                emit_valid = 1'b1;
                spec       = b;
            end

            if (!emit && in_item.frame_end)
            begin
                done_next = 1'b1;
                emit      = 1'b1;
            end
        end
    end

    assign res_valid = accept && emit;

    always_comb
    begin
        res_item.header_valid    = emit_valid;
        res_item.frame_kind      = cw_next[2:0] & FrameKindMask;
        res_item.control_flags   = cw_next[6:3];
        res_item.dest_mode       = map_mode(cw_next[11:10]);
        res_item.src_mode        = map_mode(cw_next[15:14]);
        res_item.sequence_number = seq_next;
        res_item.pan_id          = pan_next;
        res_item.dest_short      = dest_next;
        res_item.src_short       = src_next;
        res_item.unit_specifier  = spec;
        res_item.bytes_parsed    = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b1;
            cw_reg   <= '0;
            seq_reg  <= '0;
            pan_reg  <= '0;
            dest_reg <= '0;
            src_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
            cw_reg   <= cw_next;
            seq_reg  <= seq_next;
            pan_reg  <= pan_next;
            dest_reg <= dest_next;
            src_reg  <= src_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mfhp_out_buffer.sv =====
// Result register with a skid stage so the input side keeps flowing through a stall until the skid stage is full.
`timescale 1ns / 1ps
`default_nettype none

module mfhp_out_buffer
    import mfhp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_valid,
    input  wire out_item_t res_item,
    output logic           up_ready,
    mfhp_stream_if.source  header
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_data_reg, skid_data_next;

    assign up_ready       = !skid_valid_reg;
    assign header.valid   = out_valid_reg;
    assign header.payload = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || header.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_item;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the MAC frame header parser with a built-in header predictor.
`timescale 1ns / 1ps

module tb_top;
    import mfhp_pkg::*;

    localparam int IdleChance  = 23;
    localparam int HoldCycles  = 300;
    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 20;
    localparam int TargetBytes = 600;

    logic clk;
    logic rst_n;

    mfhp_stream_if #(.payload_t(in_item_t))  frame_if ();
    mfhp_stream_if #(.payload_t(out_item_t)) header_if ();

    mac_frame_header_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .header (header_if)
    );

    logic [3:0]  parse_pos;
    bit          parse_idle;
    logic [15:0] fc_word;
    logic [7:0]  seq_byte;
    logic [15:0] pan_word;
    logic [15:0] dst_word;
    logic [15:0] src_word;

    out_item_t   expected_headers[$];
    logic [7:0]  frame_bytes[$];
    int          error_count;
    int          consumed_bytes;
    int          stall_cycles;
    bit          sender_steady;
    bit          receiver_steady;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [1:0] decode_addr_mode(input logic [1:0] raw);
        if (raw == ModeRawShort)
        begin
            return ModeShort;
        end
        if (raw == ModeRawExt)
        begin
            return ModeExt;
        end
        return ModeNone;
    endfunction

    function automatic int addr_len(input logic [1:0] raw);
        return (raw == ModeRawShort) ? int'(ShortLen) : 0;
    endfunction

    task automatic record_header(input bit valid, input logic [7:0] spec,
                                 input logic [3:0] count);
        out_item_t hdr;
        hdr.header_valid    = valid;
        hdr.frame_kind      = fc_word[2:0];
        hdr.control_flags   = fc_word[6:3];
        hdr.dest_mode       = decode_addr_mode(fc_word[11:10]);
        hdr.src_mode        = decode_addr_mode(fc_word[15:14]);
        hdr.sequence_number = seq_byte;
        hdr.pan_id          = pan_word;
        hdr.dest_short      = dst_word;
        hdr.src_short       = src_word;
        hdr.unit_specifier  = spec;
        hdr.bytes_parsed    = count;
        expected_headers.push_back(hdr);
    endtask

    task automatic parse_frame_byte(input in_item_t item);
        logic [3:0] pos;
        int         dest_len;
        int         src_len;
        bit         complete;
        if (item.frame_start)
        begin
            parse_pos  = '0;
            fc_word    = '0;
            seq_byte   = '0;
            pan_word   = '0;
            dst_word   = '0;
            src_word   = '0;
            parse_idle = 1'b0;
        end
        if (parse_idle)
        begin
            return;
        end
        consumed_bytes++;
        pos      = parse_pos;
        dest_len = addr_len(fc_word[11:10]);
        src_len  = addr_len(fc_word[15:14]);
        complete = 1'b0;
        if (pos == PosFcLow)
        begin
            fc_word[7:0] = item.data_byte;
        end
        else if (pos == PosFcHigh)
        begin
            fc_word[15:8] = item.data_byte;
        end
        else if (pos == PosSeq)
        begin
            seq_byte = item.data_byte;
        end
        else if (pos == PosPanLow)
        begin
            pan_word[7:0] = item.data_byte;
        end
        else if (pos == PosPanHigh)
        begin
            pan_word[15:8] = item.data_byte;
        end
        else if (pos < PosAddr + dest_len)
        begin
            if (pos == PosAddr)
            begin
                dst_word[7:0] = item.data_byte;
            end
            else
            begin
                dst_word[15:8] = item.data_byte;
            end
        end
        else if (pos < PosAddr + dest_len + src_len)
        begin
            if (pos == PosAddr + dest_len)
            begin
                src_word[7:0] = item.data_byte;
            end
            else
            begin
                src_word[15:8] = item.data_byte;
            end
        end
        else
        begin
            complete = 1'b1;
        end
        parse_pos = pos + 4'd1;
        if (complete)
        begin
            parse_idle = 1'b1;
            record_header(1'b1, item.data_byte, parse_pos);
        end
        else if (item.frame_end)
        begin
            parse_idle = 1'b1;
            record_header(1'b0, 8'h00, parse_pos);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] data, input bit start, input bit last);
        in_item_t item;
        item.data_byte   = data;
        item.frame_start = start;
        item.frame_end   = last;
        while (!sender_steady && $urandom_range(99) < IdleChance)
        begin
            frame_if.valid = 1'b0;
            @(negedge clk);
        end
        frame_if.valid   = 1'b1;
        frame_if.payload = item;
        do
        begin
            @(posedge clk);
        end
        while (!frame_if.ready);
        parse_frame_byte(item);
        @(negedge clk);
        frame_if.valid = 1'b0;
    endtask

    task automatic build_header(input logic [15:0] fc, input logic [7:0] seq,
                                input logic [15:0] pan, input logic [15:0] dst,
                                input logic [15:0] src, input logic [7:0] spec,
                                output int hlen);
        frame_bytes.delete();
        frame_bytes.push_back(fc[7:0]);
        frame_bytes.push_back(fc[15:8]);
        frame_bytes.push_back(seq);
        frame_bytes.push_back(pan[7:0]);
        frame_bytes.push_back(pan[15:8]);
        if (fc[11:10] == ModeRawShort)
        begin
            frame_bytes.push_back(dst[7:0]);
            frame_bytes.push_back(dst[15:8]);
        end
        if (fc[15:14] == ModeRawShort)
        begin
            frame_bytes.push_back(src[7:0]);
            frame_bytes.push_back(src[15:8]);
        end
        frame_bytes.push_back(spec);
        hlen = frame_bytes.size();
    endtask

    task automatic send_frame_bytes(input int count, input int end_index);
        for (int i = 0; i < count; i++)
        begin
            send_byte(frame_bytes[i], i == 0, i == end_index);
        end
    endtask

    task automatic send_random_frame();
        logic [15:0] fc;
        int          hlen;
        int          kind;
        int          count;
        fc = 16'($urandom);
        if ($urandom_range(99) < 60)
        begin
            fc[11:10] = ModeRawShort;
        end
        if ($urandom_range(99) < 60)
        begin
            fc[15:14] = ModeRawShort;
        end
        build_header(fc, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom), hlen);
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            count = hlen + $urandom_range(0, 3);
            while (frame_bytes.size() < count)
            begin
                frame_bytes.push_back(8'($urandom));
            end
            send_frame_bytes(count, ($urandom_range(3) == 0) ? -1 : count - 1);
        end
        else if (kind < 85)
        begin
            count = $urandom_range(1, hlen - 1);
            send_frame_bytes(count, count - 1);
        end
        else if (kind < 95)
        begin
            send_frame_bytes($urandom_range(1, hlen - 1), -1);
        end
        else
        begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++)
            begin
                send_byte(8'($urandom), 1'b0, 1'($urandom));
            end
        end
    endtask

    task automatic wait_for_headers();
        frame_if.valid = 1'b0;
        while (expected_headers.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
    endtask

    task automatic test_one_byte_frame();
        send_byte(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_full_header();
        int hlen;
        build_header(16'hAAFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, hlen);
        send_frame_bytes(hlen, hlen - 1);
    endtask

    task automatic test_no_address_header();
        int hlen;
        build_header(16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, hlen);
        frame_bytes.push_back(8'h00);
        send_frame_bytes(hlen + 1, hlen);
    endtask

    task automatic test_early_end();
        int hlen;
        build_header(16'h4C55, 8'h3C, 16'h1234, 16'h0000, 16'h0000, 8'h77, hlen);
        send_frame_bytes(4, 3);
    endtask

    task automatic test_streaming_frames();
        int stop_at;
        stop_at         = consumed_bytes + 150;
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        while (consumed_bytes < stop_at)
        begin
            send_random_frame();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 2 == 0)
            begin
                send_byte(8'($urandom), 1'b1, 1'b1);
            end
            else
            begin
                send_byte(8'($urandom), 1'b1, 1'b0);
                send_byte(8'($urandom), 1'b0, 1'b1);
            end
        end
        while (hold_request)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_drain_pause();
        repeat (5)
        begin
            send_random_frame();
        end
        wait_for_headers();
        repeat (5)
        begin
            send_random_frame();
        end
    endtask

    task automatic test_random_frames();
        while (consumed_bytes < TargetBytes)
        begin
            send_random_frame();
        end
    endtask

    initial
    begin
        parse_idle       = 1'b1;
        parse_pos        = '0;
        fc_word          = '0;
        seq_byte         = '0;
        pan_word         = '0;
        dst_word         = '0;
        src_word         = '0;
        error_count      = 0;
        consumed_bytes   = 0;
        sender_steady    = 1'b0;
        receiver_steady  = 1'b0;
        hold_request     = 1'b0;
        rst_n            = 1'b0;
        frame_if.valid   = 1'b0;
        frame_if.payload = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_bytes();
        test_one_byte_frame();
        test_full_header();
        test_no_address_header();
        test_early_end();
        test_streaming_frames();
        test_backpressure();
        test_drain_pause();
        test_random_frames();

        wait_for_headers();
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        header_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                header_if.ready = 1'b0;
                repeat (HoldCycles - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                header_if.ready = receiver_steady || ($urandom_range(99) >= IdleChance);
            end
        end
    end

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && header_if.valid && header_if.ready)
        begin
            got = header_if.payload;
            if (expected_headers.size() == 0)
            begin
                $error("header transaction with no header expected");
                error_count++;
            end
            else
            begin
                want = expected_headers.pop_front();
                compare_field("header_valid", 16'(want.header_valid),
                              16'(got.header_valid));
                compare_field("frame_kind", 16'(want.frame_kind), 16'(got.frame_kind));
                compare_field("control_flags", 16'(want.control_flags),
                              16'(got.control_flags));
                compare_field("dest_mode", 16'(want.dest_mode), 16'(got.dest_mode));
                compare_field("src_mode", 16'(want.src_mode), 16'(got.src_mode));
                compare_field("sequence_number", 16'(want.sequence_number),
                              16'(got.sequence_number));
                compare_field("pan_id", want.pan_id, got.pan_id);
                compare_field("dest_short", want.dest_short, got.dest_short);
                compare_field("src_short", want.src_short, got.src_short);
                compare_field("unit_specifier", 16'(want.unit_specifier),
                              16'(got.unit_specifier));
                compare_field("bytes_parsed", 16'(want.bytes_parsed),
                              16'(got.bytes_parsed));
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((frame_if.valid && frame_if.ready) || (header_if.valid && header_if.ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= StallLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
